>>> hdl/u2a_pkg.sv
`default_nettype none
package u2a_pkg;

	localparam int QueueDepth = 4;
	localparam int QueuePtrW = $clog2(QueueDepth);

	// replacement kinds
	localparam logic [2:0] K_SQUOTE = 3'd0;
	localparam logic [2:0] K_DQUOTE = 3'd1;
	localparam logic [2:0] K_ENDASH = 3'd2;
	localparam logic [2:0] K_SPDASH = 3'd3;
	localparam logic [2:0] K_ELLIPSIS = 3'd4;
	localparam logic [2:0] K_REG = 3'd5;
	localparam logic [2:0] K_TM = 3'd6;
	localparam logic [2:0] K_SPACE = 3'd7;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      cnt;
		logic            eot;
	} u2a_job_t;

	typedef struct packed {
		u2a_job_t        job;
		logic [1:0][7:0] held;
		logic [1:0]      held_cnt;
	} u2a_step_t;

	typedef struct packed {
		logic [1:0] len;
		logic [2:0] kind;
	} u2a_match_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      len;
	} u2a_text_t;

	// full sequence at the start of buf_b, len zero when none
	function automatic u2a_match_t u2a_match(input logic [2:0][7:0] buf_b, input logic [1:0] n);
		u2a_match_t m;
		m = '0;
		if (n >= 2'd2 && buf_b[0] == 8'hC2 && buf_b[1] == 8'hAE) begin
			m.len = 2'd2;
			m.kind = K_REG;
		end else if (n == 2'd3 && buf_b[0] == 8'hE2 && buf_b[1] == 8'h80) begin
			m.len = 2'd3;
			case (buf_b[2]) inside
				8'h98, 8'h99: m.kind = K_SQUOTE;
				8'h9C, 8'h9D: m.kind = K_DQUOTE;
				8'h93: m.kind = K_ENDASH;
				8'h94, 8'hA2: m.kind = K_SPDASH;
				8'hA6: m.kind = K_ELLIPSIS;
				[8'h80:8'h8A], 8'hAF: m.kind = K_SPACE;
				default: m.len = 2'd0;
			endcase
		end else if (n == 2'd3 && buf_b[0] == 8'hE2 && buf_b[1] == 8'h84 && buf_b[2] == 8'hA2) begin
			m.len = 2'd3;
			m.kind = K_TM;
		end else if (n == 2'd3 && buf_b[0] == 8'hE3 && buf_b[1] == 8'h80 && buf_b[2] == 8'h80) begin
			m.len = 2'd3;
			m.kind = K_SPACE;
		end
		return m;
	endfunction

	function automatic logic u2a_prefix(input logic [2:0][7:0] buf_b, input logic [1:0] n);
		logic p;
		p = 1'b0;
		if (n == 2'd1) begin
			p = buf_b[0] inside {8'hC2, 8'hE2, 8'hE3};
		end else if (n == 2'd2) begin
			p = (buf_b[0] == 8'hE2 && (buf_b[1] == 8'h80 || buf_b[1] == 8'h84)) ||
			    (buf_b[0] == 8'hE3 && buf_b[1] == 8'h80);
		end
		return p;
	endfunction

	// ascii text, first character in byte 0
	function automatic u2a_text_t u2a_text(input logic [2:0] kind);
		u2a_text_t t;
		t = '0;
		case (kind)
			K_SQUOTE: begin t.bytes[0] = 8'h27; t.len = 3'd1; end
			K_DQUOTE: begin t.bytes[0] = 8'h22; t.len = 3'd1; end
			K_ENDASH: begin t.bytes[0] = 8'h2D; t.len = 3'd1; end
			K_SPDASH: begin t.bytes = {8'h00, 8'h20, 8'h2D, 8'h20}; t.len = 3'd3; end
			K_ELLIPSIS: begin t.bytes = {8'h00, 8'h2E, 8'h2E, 8'h2E}; t.len = 3'd3; end
			K_REG: begin t.bytes = {8'h00, 8'h29, 8'h52, 8'h28}; t.len = 3'd3; end
			K_TM: begin t.bytes = {8'h29, 8'h4D, 8'h54, 8'h28}; t.len = 3'd4; end
			K_SPACE: begin t.bytes[0] = 8'h20; t.len = 3'd1; end
			default: t = '0;
		endcase
		return t;
	endfunction

	// one input byte against the held prefix, at most three match rounds
	function automatic u2a_step_t u2a_step(input logic [1:0][7:0] held, input logic [1:0] held_cnt,
	                                       input logic [7:0] b, input logic eot);
		u2a_step_t r;
		logic [2:0][7:0] buf_b;
		logic [1:0] n;
		logic [1:0] used;
		logic done;
		logic [2:0] p;
		logic [3:0] sum;
		u2a_match_t m;
		u2a_text_t t;
		r = '0;
		buf_b = {8'h00, held};
		case (held_cnt)
			2'd0: buf_b[0] = b;
			2'd1: buf_b[1] = b;
			default: buf_b[2] = b;
		endcase
		n = held_cnt + 2'd1;
		done = 1'b0;
		for (int it = 0; it < 3; it++) begin
			if (!done && n != 2'd0) begin
				m = u2a_match(buf_b, n);
				used = 2'd0;
				if (m.len != 2'd0) begin
					t = u2a_text(m.kind);
					for (int j = 0; j < 4; j++) begin
						p = r.job.cnt + 3'(j);
						if (3'(j) < t.len && p < 3'd4)
							r.job.bytes[p[1:0]] = t.bytes[j];
					end
					sum = {1'b0, r.job.cnt} + {1'b0, t.len};
					r.job.cnt = (sum > 4'd4) ? 3'd4 : sum[2:0];
					used = m.len;
				end else if (!eot && u2a_prefix(buf_b, n)) begin
					done = 1'b1;
				end else begin
					if (r.job.cnt < 3'd4) begin
						r.job.bytes[r.job.cnt[1:0]] = buf_b[0];
						r.job.cnt = r.job.cnt + 3'd1;
					end
					used = 2'd1;
				end
				case (used)
					2'd1: buf_b = {8'h00, buf_b[2], buf_b[1]};
					2'd2: buf_b = {16'h0000, buf_b[2]};
					2'd3: buf_b = '0;
					default: buf_b = buf_b;
				endcase
				n = n - used;
			end
		end
		r.job.eot = eot;
		r.held = buf_b[1:0];
		r.held_cnt = n;
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hdl/utf8_punctuation_to_ascii_top.sv
// channel   dir  tdata                tlast        tuser
// s_axis    in   [7:0] text_byte      end_of_text  -
// m_axis    out  [7:0] out_byte       run_last     [0] text_last
//
// an input byte is taken in the cycle it arrives whenever the job queue has room
// each byte gives zero to four output bytes; the output serializer sends one a cycle
// while the receiver is ready, so the sustained input rate is one byte per output byte it
// produces, at most one a cycle; accepted bytes pass the queue and the output register
// reset clears held prefix, queue and output valid; no clearing pass
// a stalled output fills the four-entry queue before the input side stalls
`default_nettype none
module utf8_punctuation_to_ascii_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // text_byte
	input  wire logic       s_axis_tlast,  // end_of_text
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // out_byte
	output logic            m_axis_tlast,  // run_last
	output logic            m_axis_tuser   // text_last
);

	logic              q_full;
	logic              q_push;
	logic              q_pop;
	logic              q_head_valid;
	u2a_pkg::u2a_job_t q_push_job;
	u2a_pkg::u2a_job_t q_head_job;
	logic [1:0]        held_cnt;

	u2a_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_job         (q_push_job),
		.held_cnt      (held_cnt)
	);

	u2a_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (q_push_job),
		.full       (q_full),
		.head_valid (q_head_valid),
		.head_job   (q_head_job),
		.pop        (q_pop)
	);

	u2a_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (q_head_valid),
		.head_job      (q_head_job),
		.pop           (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("job queue written while full");

	a_text_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("text end without run end");

	a_flush_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> held_cnt == 2'd0)
		else $error("held bytes left after end of text");

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_cnt != 2'd3)
		else $error("held count out of range");
`endif

endmodule
`default_nettype wire

>>> hdl/u2a_front.sv
`default_nettype none
module u2a_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [7:0]        s_axis_tdata,  // text_byte
	input  wire logic              s_axis_tlast,  // end_of_text
	input  wire logic              q_full,
	output logic                   q_push,
	output u2a_pkg::u2a_job_t      q_job,
	output logic [1:0]             held_cnt
);

	logic [1:0][7:0] held_q;
	logic [1:0]      held_cnt_q;
	logic            accept;
	u2a_pkg::u2a_step_t step;

	assign s_axis_tready = !q_full;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign step = u2a_pkg::u2a_step(held_q, held_cnt_q, s_axis_tdata, s_axis_tlast);
	// a byte that only extends the held prefix makes no job
	assign q_push = accept && (step.job.cnt != 3'd0);
	assign q_job = step.job;
	assign held_cnt = held_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
		end else if (accept) begin
			held_cnt_q <= step.held_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= step.held;
		end
	end

endmodule
`default_nettype wire

>>> hdl/u2a_queue.sv
`default_nettype none
module u2a_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire u2a_pkg::u2a_job_t push_job,
	output logic                   full,
	output logic                   head_valid,
	output u2a_pkg::u2a_job_t      head_job,
	input  wire logic              pop
);

	localparam int PtrW = u2a_pkg::QueuePtrW;

	u2a_pkg::u2a_job_t slot_q [u2a_pkg::QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [PtrW:0]   count_q;

	assign full = (count_q == (PtrW+1)'(u2a_pkg::QueueDepth));
	assign head_valid = (count_q != '0);
	assign head_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + PtrW'(1);
			if (push && !pop) count_q <= count_q + (PtrW+1)'(1);
			else if (pop && !push) count_q <= count_q - (PtrW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule
`default_nettype wire

>>> hdl/u2a_back.sv
`default_nettype none
module u2a_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              head_valid,
	input  wire u2a_pkg::u2a_job_t head_job,
	output logic                   pop,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [7:0]             m_axis_tdata,  // out_byte
	output logic                   m_axis_tlast,  // run_last
	output logic                   m_axis_tuser   // text_last
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       out_text_q;
	logic       slot_free;
	logic       load;
	logic       last_byte;

	assign slot_free = !out_valid_q || m_axis_tready;
	assign load = head_valid && slot_free;
	assign last_byte = ({1'b0, idx_q} + 3'd1) == head_job.cnt;
	assign pop = load && last_byte;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_byte_q;
	assign m_axis_tlast = out_last_q;
	assign m_axis_tuser = out_text_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q <= 2'd0;
		end else begin
			if (slot_free) out_valid_q <= head_valid;
			if (load) idx_q <= last_byte ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= head_job.bytes[idx_q];
			out_last_q <= last_byte;
			out_text_q <= last_byte && head_job.eot;
		end
	end

endmodule
`default_nettype wire

>>> tb/sv/utf8_punctuation_to_ascii_top_tb.sv
`timescale 1ns / 100ps
module utf8_punctuation_to_ascii_top_tb;

	localparam int MaxOutPerByte = 4;
	localparam int HoldOffCycles = 80;
	localparam int GapPercent = 12;

	typedef logic [7:0] byte_q_t[$];

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       text_last;
	} text_out_t;

	class punct_scoreboard;
		// replacement table, first byte of a sequence in bits 23:16
		logic [23:0]  seq_code[$];
		int unsigned  seq_len[$];
		string        seq_repl[$];
		logic [7:0]   held[2];
		int unsigned  held_n;
		text_out_t    expected_bytes[$];
		int unsigned  faults;

		function new();
			held_n = 0;
			faults = 0;
			add_seq(24'hE28098, 3, "'");
			add_seq(24'hE28099, 3, "'");
			add_seq(24'hE2809C, 3, "\"");
			add_seq(24'hE2809D, 3, "\"");
			add_seq(24'hE28093, 3, "-");
			add_seq(24'hE28094, 3, " - ");
			add_seq(24'hE280A2, 3, " - ");
			add_seq(24'hE280A6, 3, "...");
			add_seq(24'hC2AE00, 2, "(R)");
			add_seq(24'hE284A2, 3, "(TM)");
			for (int c = 8'h80; c <= 8'h8A; c++)
				add_seq({16'hE280, 8'(c)}, 3, " ");
			add_seq(24'hE280AF, 3, " ");
			add_seq(24'hE38080, 3, " ");
		endfunction

		function void add_seq(logic [23:0] code, int unsigned len, string repl);
			seq_code.push_back(code);
			seq_len.push_back(len);
			seq_repl.push_back(repl);
		endfunction

		function logic [7:0] seq_byte(int i, int j);
			return seq_code[i][23 - 8 * j -: 8];
		endfunction

		// first sequence fully present at the head of the window, -1 if none
		function int find_seq(logic [7:0] win[3], int unsigned n);
			bit hit;
			for (int i = 0; i < seq_code.size(); i++) begin
				if (seq_len[i] <= n) begin
					hit = 1'b1;
					for (int j = 0; j < seq_len[i]; j++)
						if (win[j] != seq_byte(i, j))
							hit = 1'b0;
					if (hit)
						return i;
				end
			end
			return -1;
		endfunction

		function bit could_grow(logic [7:0] win[3], int unsigned n);
			bit hit;
			for (int i = 0; i < seq_code.size(); i++) begin
				if (n < seq_len[i]) begin
					hit = 1'b1;
					for (int j = 0; j < n; j++)
						if (win[j] != seq_byte(i, j))
							hit = 1'b0;
					if (hit)
						return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void note_request(logic [7:0] text_byte, logic end_of_text);
			logic [7:0]  win[3];
			logic [7:0]  outs[$];
			int unsigned n;
			int unsigned used;
			int          idx;
			text_out_t   e;
			win = '{8'h00, 8'h00, 8'h00};
			for (int k = 0; k < held_n; k++)
				win[k] = held[k];
			n = held_n;
			win[n] = text_byte;
			n++;
			while (n > 0) begin
				idx = find_seq(win, n);
				if (idx >= 0) begin
					for (int k = 0; k < seq_repl[idx].len(); k++)
						outs.push_back(seq_repl[idx][k]);
					used = seq_len[idx];
				end else if (!end_of_text && could_grow(win, n)) begin
					break;
				end else begin
					outs.push_back(win[0]);
					used = 1;
				end
				for (int k = 0; k + used < 3; k++)
					win[k] = win[k + used];
				n -= used;
			end
			held_n = n;
			for (int k = 0; k < n; k++)
				held[k] = win[k];
			while (outs.size() > MaxOutPerByte)
				void'(outs.pop_back());
			foreach (outs[k]) begin
				e.out_byte = outs[k];
				e.run_last = (k == outs.size() - 1);
				e.text_last = e.run_last && end_of_text;
				expected_bytes.push_back(e);
			end
		endfunction

		function void check_result(logic [7:0] out_byte, logic run_last, logic text_last);
			text_out_t e;
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected output, expected none, actual byte %02h last %b user %b",
				         $time, out_byte, run_last, text_last);
				faults++;
				return;
			end
			e = expected_bytes.pop_front();
			if (out_byte !== e.out_byte) begin
				$display("%0t: out_byte expected %02h actual %02h", $time, e.out_byte, out_byte);
				faults++;
			end
			if (run_last !== e.run_last) begin
				$display("%0t: run_last expected %b actual %b", $time, e.run_last, run_last);
				faults++;
			end
			if (text_last !== e.text_last) begin
				$display("%0t: text_last expected %b actual %b", $time, e.text_last, text_last);
				faults++;
			end
		endfunction

		function int unsigned open_results();
			return expected_bytes.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;  // text_byte
	logic       s_axis_tlast = 1'b0;   // end_of_text
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;          // out_byte
	logic       m_axis_tlast;          // run_last
	logic       m_axis_tuser;          // [0] text_last

	punct_scoreboard sb;
	bit          src_gaps = 1'b1;
	bit          sink_gaps = 1'b1;
	bit          hold_out = 1'b0;
	int unsigned sent_count = 0;

	utf8_punctuation_to_ascii_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_request(s_axis_tdata, s_axis_tlast);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
	end

	// receiver side: random stalls, or one long hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_out) begin
				m_axis_tready <= 1'b0;
				repeat (HoldOffCycles) @(posedge clk);
				hold_out = 1'b0;
			end else begin
				m_axis_tready <= (sink_gaps && $urandom_range(99) < GapPercent) ? 1'b0 : 1'b1;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eot);
		if (src_gaps && $urandom_range(99) < GapPercent) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= eot;
		do @(posedge clk); while (!s_axis_tready);
		sent_count++;
	endtask

	task automatic send_run(input byte_q_t bytes);
		foreach (bytes[i])
			send_byte(bytes[i], i == bytes.size() - 1);
	endtask

	// random text: mostly whole sequences, some broken prefixes and loose bytes
	task automatic send_text(input int unsigned tokens);
		byte_q_t     bytes;
		int          idx;
		int unsigned cut;
		int unsigned pick;
		for (int t = 0; t < tokens; t++) begin
			pick = $urandom_range(99);
			idx = $urandom_range(sb.seq_code.size() - 1);
			if (pick < 50) begin
				for (int j = 0; j < sb.seq_len[idx]; j++)
					bytes.push_back(sb.seq_byte(idx, j));
			end else if (pick < 65) begin
				cut = $urandom_range(1, sb.seq_len[idx] - 1);
				for (int j = 0; j < cut; j++)
					bytes.push_back(sb.seq_byte(idx, j));
				bytes.push_back(8'($urandom_range(255)));
			end else begin
				bytes.push_back(8'($urandom_range(255)));
			end
		end
		// text cut off inside a sequence, flushed by the end flag
		if ($urandom_range(99) < 20) begin
			idx = $urandom_range(sb.seq_code.size() - 1);
			cut = $urandom_range(1, sb.seq_len[idx] - 1);
			for (int j = 0; j < cut; j++)
				bytes.push_back(sb.seq_byte(idx, j));
		end
		send_run(bytes);
	endtask

	// an edge first so the last accepted request is already noted
	task automatic drain_wait();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.open_results() != 0)
			@(posedge clk);
	endtask

	initial begin
		byte_q_t d;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, several replacements, broken prefixes, flush of a held prefix
		d = '{8'h00, 8'hFF, 8'hE2, 8'h80, 8'h98, 8'hC2, 8'hAE, 8'hE2, 8'h84, 8'hA2,
		      8'hE2, 8'h80, 8'h41, 8'hE2, 8'hE2, 8'h80, 8'hA6, 8'hE2, 8'h80, 8'h94,
		      8'hE3, 8'h80};
		send_run(d);
		d = '{8'hC2};
		send_run(d);
		d = '{8'hE3, 8'h80, 8'h80};
		send_run(d);
		d = '{8'h7F};
		send_run(d);
		drain_wait();

		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		while (sent_count < 100)
			send_text($urandom_range(1, 10));
		src_gaps = 1'b1;
		sink_gaps = 1'b1;

		// long output stall while the input keeps offering bytes
		hold_out = 1'b1;
		while (sent_count < 160)
			send_text($urandom_range(1, 10));
		drain_wait();

		while (sent_count < 215)
			send_text($urandom_range(1, 6));
		drain_wait();
		repeat (20) @(posedge clk);

		if (sb.faults == 0 && sb.open_results() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#400000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
